// ===== rtl/assert_macros.svh =====
// Assertion helpers for the connection engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/tcce_pkg.sv =====
package tcce_pkg;

  localparam int unsigned MaxSegData = 1460;
  localparam int unsigned ResultCap = 45;
  localparam int unsigned HdrBytes = 20;
  localparam logic [15:0] PortReset = 16'd49152;
  localparam logic [15:0] WindowReset = 16'd4096;
  localparam int unsigned CmdQDepth = 2;

  localparam logic [7:0] FlagFin = 8'h01;
  localparam logic [7:0] FlagSyn = 8'h02;
  localparam logic [7:0] FlagRst = 8'h04;
  localparam logic [7:0] FlagPsh = 8'h08;
  localparam logic [7:0] FlagAck = 8'h10;

  localparam logic RegWindow = 1'b0;
  localparam logic RegPortBase = 1'b1;

  typedef enum logic [2:0] {
    CmdConnect = 3'd0,
    CmdSend    = 3'd1,
    CmdRecv    = 3'd2,
    CmdConsume = 3'd3,
    CmdClose   = 3'd4,
    CmdTimeout = 3'd5,
    CmdRsvd6   = 3'd6,
    CmdRsvd7   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    StClosed       = 2'd0,
    StSynSent      = 2'd1,
    StEstablished  = 2'd2,
    StRemoteClosed = 2'd3
  } conn_state_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatRejected = 2'd1,
    StatDropped  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkExec,
    BkSend
  } bk_state_e;

  // Classified command as handed from front end to back end.
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] dest_port;
    logic [31:0] init_seq;
    logic [7:0]  seg_flags;
    logic [5:0]  seg_offs;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] length;
    logic        short_seg;
    logic        bad_offs;
    logic [15:0] seg_dlen;
  } cmd_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_flags;
    logic [31:0] tx_sequence;
    logic [31:0] tx_acknowledge;
    logic [15:0] tx_local_port;
    logic [15:0] tx_remote_port;
    logic [10:0] tx_data_len;
    logic [15:0] tx_data_offset;
    logic [1:0]  conn_state;
    logic [10:0] accepted_len;
    logic [1:0]  status;
    logic        last;
  } result_t;

endpackage

// ===== rtl/tcp_client_connection_engine.sv =====
// Channel   Handshake            Transfers
// command   push / full          command_i and segment header fields
// result    pop / empty          tx descriptor, conn_state_o, status_o, last_o
// config    cfg_we_i             cfg_idx_i, cfg_data_i (no wait)
// A command enters a two-entry queue when accepted; the back end takes it into
// its Exec state and then registers its result, so it finishes one command
// before it takes the next.
// A send passes through Exec before its first chunk, then one chunk per cycle
// while pop keeps up, up to 45 chunks. Reset clears all connection state.
// A stalled result holds the back end; the queue takes commands until full.
`include "assert_macros.svh"

module tcp_client_connection_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command_i,
  input  logic [31:0] peer_ip_i,
  input  logic [15:0] peer_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] initial_sequence_i,
  input  logic [7:0]  seg_flags_i,
  input  logic [3:0]  seg_offset_words_i,
  input  logic [31:0] seg_sequence_i,
  input  logic [31:0] seg_acknowledge_i,
  input  logic [15:0] length_i,
  output logic        empty,
  input  logic        pop,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_flags_o,
  output logic [31:0] tx_sequence_o,
  output logic [31:0] tx_acknowledge_o,
  output logic [15:0] tx_local_port_o,
  output logic [15:0] tx_remote_port_o,
  output logic [10:0] tx_data_len_o,
  output logic [15:0] tx_data_offset_o,
  output logic [1:0]  conn_state_o,
  output logic [10:0] accepted_len_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  tcce_pkg::cmd_t    in_cmd, q_cmd;
  tcce_pkg::result_t res;
  logic q_valid, q_take, res_valid;

  always_comb begin
    in_cmd = '0;
    in_cmd.cmd = tcce_pkg::cmd_e'(command_i);
    in_cmd.peer_ip = peer_ip_i;
    in_cmd.peer_port = peer_port_i;
    in_cmd.dest_port = dest_port_i;
    in_cmd.init_seq = initial_sequence_i;
    in_cmd.seg_flags = seg_flags_i;
    in_cmd.seg_offs = {2'b00, seg_offset_words_i};
    in_cmd.seg_seq = seg_sequence_i;
    in_cmd.seg_ack = seg_acknowledge_i;
    in_cmd.length = length_i;
  end

  tcce_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_take_i(q_take), .q_cmd_o(q_cmd)
  );

  tcce_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_take_o(q_take), .q_cmd_i(q_cmd),
    .res_valid_o(res_valid), .res_take_i(pop), .res_o(res)
  );

  assign empty = !res_valid;
  assign tx_valid_o = res.tx_valid;
  assign tx_flags_o = res.tx_flags;
  assign tx_sequence_o = res.tx_sequence;
  assign tx_acknowledge_o = res.tx_acknowledge;
  assign tx_local_port_o = res.tx_local_port;
  assign tx_remote_port_o = res.tx_remote_port;
  assign tx_data_len_o = res.tx_data_len;
  assign tx_data_offset_o = res.tx_data_offset;
  assign conn_state_o = res.conn_state;
  assign accepted_len_o = res.accepted_len;
  assign status_o = res.status;
  assign last_o = res.last;

  `ASSERT_CLK(a_idle_tx_zero, clk_i, rst_ni, (!empty && !tx_valid_o) |-> (tx_flags_o == '0 && tx_data_len_o == '0), "idle result carries tx fields")
  `ASSERT_CLK(a_chunk_bound, clk_i, rst_ni, !empty |-> (tx_data_len_o <= 11'(tcce_pkg::MaxSegData)), "chunk too long")
  `ASSERT_CLK(a_result_hold, clk_i, rst_ni, ($past(!empty) && !$past(pop)) |-> (!empty && $stable(tx_sequence_o)), "stalled result changed")

endmodule

// ===== rtl/tcce_front.sv =====
module tcce_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  tcce_pkg::cmd_t    cmd_i,
  output logic              q_valid_o,
  input  logic              q_take_i,
  output tcce_pkg::cmd_t    q_cmd_o
);

  localparam int unsigned PtrW = $clog2(tcce_pkg::CmdQDepth);

  tcce_pkg::cmd_t mem_q [tcce_pkg::CmdQDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  tcce_pkg::cmd_t  cls;
  logic            do_push;

  // Precompute the receive header checks.
  always_comb begin
    cls = cmd_i;
    cls.seg_offs = {cmd_i.seg_offs[3:0], 2'b00};
    cls.short_seg = cmd_i.length < 16'(tcce_pkg::HdrBytes);
    cls.bad_offs = (cls.seg_offs < 6'(tcce_pkg::HdrBytes)) ||
                   ({10'd0, cls.seg_offs} > cmd_i.length);
    cls.seg_dlen = cmd_i.length - {10'd0, cls.seg_offs};
  end

  assign full_o = (cnt_q == (PtrW+1)'(tcce_pkg::CmdQDepth));
  assign do_push = push_i && !full_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = wr_q + 1'b1;
    end
    if (q_take_i && q_valid_o) begin
      rd_d = rd_q + 1'b1;
    end
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(q_take_i && q_valid_o);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/tcce_back.sv =====
module tcce_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               q_valid_i,
  output logic               q_take_o,
  input  tcce_pkg::cmd_t     q_cmd_i,
  output logic               res_valid_o,
  input  logic               res_take_i,
  output tcce_pkg::result_t  res_o
);

  tcce_pkg::bk_state_e bst_q, bst_d;
  tcce_pkg::conn_state_e cst_q, cst_d;
  tcce_pkg::cmd_t cur_q, cur_d;
  logic [15:0] window_q, port_base_q;
  logic [31:0] raddr_q, raddr_d, nss_q, nss_d, nrs_q, nrs_d;
  logic [15:0] rport_q, rport_d, lport_q, lport_d, pcnt_q, pcnt_d;
  logic [10:0] slen_q, slen_d;
  logic        sfull_q, sfull_d;
  logic [15:0] rem_q, rem_d, off_q, off_d;
  logic [5:0]  nchunk_q, nchunk_d;
  tcce_pkg::result_t res_q, res_d;
  logic        rv_q, rv_d;
  logic [15:0] pnext;
  logic [10:0] chunk, acc;
  logic        emit, r_valid, r_last, fin_ok;
  logic [7:0]  r_flags;
  logic [10:0] r_dlen, r_acc;
  logic [15:0] r_doff;
  logic [1:0]  r_stat;
  logic [31:0] r_seq;

  assign res_valid_o = rv_q;
  assign res_o = res_q;
  assign chunk = (rem_q > 16'(tcce_pkg::MaxSegData)) ? 11'(tcce_pkg::MaxSegData)
                                                     : rem_q[10:0];
  assign acc = (cur_q.seg_dlen > 16'(tcce_pkg::MaxSegData)) ?
               11'(tcce_pkg::MaxSegData) : cur_q.seg_dlen[10:0];
  assign pnext = pcnt_q + 16'd1;

  always_comb begin
    bst_d = bst_q; cst_d = cst_q; cur_d = cur_q;
    raddr_d = raddr_q; nss_d = nss_q; nrs_d = nrs_q;
    rport_d = rport_q; lport_d = lport_q; pcnt_d = pcnt_q;
    slen_d = slen_q; sfull_d = sfull_q;
    rem_d = rem_q; off_d = off_q; nchunk_d = nchunk_q;
    res_d = res_q;
    rv_d = rv_q && !res_take_i;
    q_take_o = 1'b0;
    emit = 1'b0; r_valid = 1'b0; r_flags = '0; r_dlen = '0; r_doff = '0;
    r_acc = '0; r_stat = tcce_pkg::StatOk; r_last = 1'b1; r_seq = nss_q;
    fin_ok = 1'b0;
    unique case (bst_q)
      tcce_pkg::BkIdle: begin
        if (q_valid_i) begin
          q_take_o = 1'b1;
          cur_d = q_cmd_i;
          bst_d = tcce_pkg::BkExec;
        end
      end
      tcce_pkg::BkExec: begin
        if (!rv_d) begin
          emit = 1'b1;
          bst_d = tcce_pkg::BkIdle;
          unique case (cur_q.cmd)
            tcce_pkg::CmdConnect: begin
              raddr_d = cur_q.peer_ip;
              rport_d = cur_q.peer_port;
              lport_d = pcnt_q;
              pcnt_d = (pnext == '0) ? port_base_q : pnext;
              nrs_d = '0; sfull_d = 1'b0; slen_d = '0;
              cst_d = tcce_pkg::StSynSent;
              nss_d = cur_q.init_seq + 32'd1;
              r_valid = 1'b1; r_flags = tcce_pkg::FlagSyn;
              r_seq = cur_q.init_seq;
            end
            tcce_pkg::CmdSend: begin
              if (cst_q != tcce_pkg::StEstablished) begin
                r_stat = tcce_pkg::StatRejected;
              end else if (cur_q.length != '0) begin
                emit = 1'b0;
                rem_d = cur_q.length; off_d = '0; nchunk_d = '0;
                bst_d = tcce_pkg::BkSend;
              end
            end
            tcce_pkg::CmdRecv: begin
              if (cur_q.short_seg || cst_q == tcce_pkg::StClosed ||
                  cur_q.peer_ip != raddr_q || cur_q.peer_port != rport_q ||
                  cur_q.dest_port != lport_q) begin
                r_stat = tcce_pkg::StatDropped;
              end else if ((cur_q.seg_flags & tcce_pkg::FlagRst) != '0) begin
                cst_d = tcce_pkg::StClosed;
              end else if (cur_q.bad_offs) begin
                r_stat = tcce_pkg::StatDropped;
              end else if (cst_q == tcce_pkg::StSynSent) begin
                if ((cur_q.seg_flags & tcce_pkg::FlagSyn) != '0 &&
                    (cur_q.seg_flags & tcce_pkg::FlagAck) != '0 &&
                    cur_q.seg_ack == nss_q) begin
                  nrs_d = cur_q.seg_seq + 32'd1;
                  r_valid = 1'b1; r_flags = tcce_pkg::FlagAck;
                  cst_d = tcce_pkg::StEstablished;
                end else begin
                  r_stat = tcce_pkg::StatDropped;
                end
              end else begin
                if (cur_q.seg_dlen != '0 && cur_q.seg_seq == nrs_q && !sfull_q) begin
                  r_acc = acc;
                  slen_d = acc; sfull_d = 1'b1;
                  nrs_d = nrs_q + {21'd0, acc};
                end
                fin_ok = (cur_q.seg_flags & tcce_pkg::FlagFin) != '0 &&
                         (cur_q.seg_seq + {16'd0, cur_q.seg_dlen}) == nrs_d;
                if (fin_ok) begin
                  nrs_d = nrs_d + 32'd1;
                  r_valid = 1'b1; r_flags = tcce_pkg::FlagAck;
                  cst_d = tcce_pkg::StRemoteClosed;
                end
              end
            end
            tcce_pkg::CmdConsume: begin
              sfull_d = 1'b0;
              r_valid = 1'b1; r_flags = tcce_pkg::FlagAck;
            end
            tcce_pkg::CmdClose: begin
              if (cst_q == tcce_pkg::StEstablished ||
                  cst_q == tcce_pkg::StRemoteClosed) begin
                r_valid = 1'b1; r_flags = tcce_pkg::FlagFin | tcce_pkg::FlagAck;
                nss_d = nss_q + 32'd1;
              end
              cst_d = tcce_pkg::StClosed;
            end
            tcce_pkg::CmdTimeout: begin
              if (cst_q == tcce_pkg::StSynSent) begin
                cst_d = tcce_pkg::StClosed;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tcce_pkg::BkSend: begin
        if (!rv_d) begin
          emit = 1'b1;
          r_valid = 1'b1;
          r_flags = tcce_pkg::FlagAck | tcce_pkg::FlagPsh;
          r_dlen = chunk; r_doff = off_q;
          nss_d = nss_q + {21'd0, chunk};
          off_d = off_q + {5'd0, chunk};
          rem_d = rem_q - {5'd0, chunk};
          nchunk_d = nchunk_q + 6'd1;
          r_last = (rem_d == '0) || (nchunk_d == 6'(tcce_pkg::ResultCap));
          if (r_last) begin
            bst_d = tcce_pkg::BkIdle;
          end
        end
      end
      default: begin
        bst_d = tcce_pkg::BkIdle;
      end
    endcase
    if (emit) begin
      rv_d = 1'b1;
      res_d.tx_valid = r_valid;
      res_d.tx_flags = r_valid ? r_flags : '0;
      res_d.tx_sequence = r_valid ? r_seq : '0;
      res_d.tx_acknowledge = (r_valid && (r_flags & tcce_pkg::FlagAck) != '0) ? nrs_d : '0;
      res_d.tx_local_port = r_valid ? lport_d : '0;
      res_d.tx_remote_port = r_valid ? rport_d : '0;
      res_d.tx_data_len = r_dlen;
      res_d.tx_data_offset = r_doff;
      res_d.conn_state = cst_d;
      res_d.accepted_len = r_acc;
      res_d.status = r_stat;
      res_d.last = r_last;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    rem_q <= rem_d;
    off_q <= off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bst_q <= tcce_pkg::BkIdle;
      cst_q <= tcce_pkg::StClosed;
      raddr_q <= '0; nss_q <= '0; nrs_q <= '0;
      rport_q <= '0; lport_q <= '0; pcnt_q <= tcce_pkg::PortReset;
      slen_q <= '0; sfull_q <= 1'b0; nchunk_q <= '0; rv_q <= 1'b0;
      window_q <= tcce_pkg::WindowReset;
      port_base_q <= tcce_pkg::PortReset;
    end else begin
      bst_q <= bst_d; cst_q <= cst_d;
      raddr_q <= raddr_d; nss_q <= nss_d; nrs_q <= nrs_d;
      rport_q <= rport_d; lport_q <= lport_d; pcnt_q <= pcnt_d;
      slen_q <= slen_d; sfull_q <= sfull_d; nchunk_q <= nchunk_d; rv_q <= rv_d;
      if (cfg_we_i && cfg_idx_i == tcce_pkg::RegWindow) begin
        window_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == tcce_pkg::RegPortBase) begin
        port_base_q <= cfg_data_i;
      end
    end
  end

  // The window register feeds no output; it and slen_q go into an unused reduction.
  logic unused_window;
  assign unused_window = ^{window_q, slen_q};

endmodule
